// ===== hdl/jkaof_pkg.sv =====
// Package for the JSON keyed-array object framer: types, constants and key table.
package jkaof_pkg;

    localparam int unsigned KeyLen = 7;

    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChLBracket  = 8'h5B;
    localparam logic [7:0] ChRBracket  = 8'h5D;
    localparam logic [7:0] ChLBrace    = 8'h7B;
    localparam logic [7:0] ChRBrace    = 8'h7D;

    localparam logic [15:0] DepthMax = 16'hFFFF;

    localparam logic [7:0]  MaxObjectsRst     = 8'd5;
    localparam logic [15:0] MaxObjectBytesRst = 16'd3071;

    // register indexes of the configuration port
    localparam logic [7:0] RegMaxObjects     = 8'd0;
    localparam logic [7:0] RegMaxObjectBytes = 8'd1;

    typedef struct packed {
        logic [2:0]  key_match_pos;
        logic        awaiting_array;
        logic        in_array;
        logic        capturing;
        logic [15:0] nest_depth;
        logic        in_string;
        logic        after_backslash;
        logic        overflow_flag;
        logic [15:0] obj_byte_count;
        logic [7:0]  object_count;
        logic        stopped;
    } scan_state_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       object_end;
        logic       object_overflowed;
        logic [7:0] objects_done;
        logic       scan_stopped;
    } scan_result_t;

    // bytes of the literal "pages", quotes included
    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = ChQuote;
            3'd1:    c = 8'h70;
            3'd2:    c = 8'h61;
            3'd3:    c = 8'h67;
            3'd4:    c = 8'h65;
            3'd5:    c = 8'h73;
            3'd6:    c = ChQuote;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/json_keyed_array_object_framer_unit.sv =====
// Top level of the JSON keyed-array object framer: state, config and output register.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  s_       | in  | s_tvalid / s_tready  | tdata: in_byte; tuser: stream_start
//  m_       | out | m_tvalid / m_tready  | tdata: out_byte, objects_done; tlast:
//           |     |                      | object_end; tuser: byte_valid,
//           |     |                      | object_overflowed, scan_stopped
//  cfg_     | in  | cfg_wr_en            | cfg_index, cfg_wdata (no read-back)
//
// One beat per cycle unless stalled: each input beat makes exactly one beat out next cycle.
// The scan step is a single pass of compare/increment logic from the state
// register into the state and output registers.
// s_tready is high while the output register is empty or being drained.
// Reset (aresetn low, synchronous) clears scan state, empties the output
// register and loads the default limits (5 objects, 3071 bytes).
module json_keyed_array_object_framer_unit import jkaof_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] stream_start
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] objects_done
    output logic        m_tlast,   // object_end
    output logic [2:0]  m_tuser,   // [0] byte_valid, [1] object_overflowed, [2] scan_stopped
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t res_next;
    scan_result_t res_reg;
    logic         out_valid_reg;
    logic [7:0]   max_objects_reg;
    logic [15:0]  max_object_bytes_reg;
    logic         s_accept;

    // output register frees up in the same cycle it is taken
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    jkaof_step u_step (
        .cur              (state_reg),
        .in_byte          (s_tdata),
        .stream_start     (s_tuser[0]),
        .max_objects      (max_objects_reg),
        .max_object_bytes (max_object_bytes_reg),
        .nxt              (state_next),
        .res              (res_next)
    );

    // scan state and limits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            max_objects_reg <= MaxObjectsRst;
            max_object_bytes_reg <= MaxObjectBytesRst;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    RegMaxObjects:     max_objects_reg <= cfg_wdata[7:0];
                    RegMaxObjectBytes: max_object_bytes_reg <= cfg_wdata;
                    default: ;  // unknown index: dropped
                endcase
            end
        end
    end

    // output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.objects_done, res_reg.out_byte};
    assign m_tlast  = res_reg.object_end;
    assign m_tuser  = {res_reg.scan_stopped, res_reg.object_overflowed, res_reg.byte_valid};

endmodule

// ===== hdl/jkaof_step.sv =====
// Per-byte scan step: next scan state and result for one input byte.
module jkaof_step import jkaof_pkg::*; (
    input  scan_state_t  cur,
    input  logic [7:0]   in_byte,
    input  logic         stream_start,
    input  logic [7:0]   max_objects,
    input  logic [15:0]  max_object_bytes,
    output scan_state_t  nxt,
    output scan_result_t res
);

    scan_state_t s0;
    logic        room;
    logic        valid;
    logic        close_obj;
    logic        in_object;
    logic [15:0] depth_dec;

    always_comb begin
        s0 = stream_start ? '0 : cur;
        nxt = s0;
        valid = 1'b0;
        close_obj = 1'b0;
        in_object = 1'b0;
        room = s0.obj_byte_count < max_object_bytes;
        depth_dec = s0.nest_depth - 16'd1;

        if (s0.stopped) begin
            // byte ignored
        end else if (!s0.in_array) begin
            if (s0.awaiting_array) begin
                if (in_byte == ChLBracket) begin
                    nxt.in_array = 1'b1;
                end
            end else if ({29'd0, s0.key_match_pos} < KeyLen
                         && in_byte == key_char(s0.key_match_pos)) begin
                nxt.key_match_pos = s0.key_match_pos + 3'd1;
                if ({29'd0, nxt.key_match_pos} == KeyLen) begin
                    nxt.awaiting_array = 1'b1;
                end
            end else begin
                nxt.key_match_pos = (in_byte == ChQuote) ? 3'd1 : 3'd0;
            end
        end else if (!s0.capturing) begin
            if (in_byte == ChLBrace) begin
                // length restarts at zero, so room is just a nonzero limit
                room = max_object_bytes != 16'd0;
                nxt.capturing = 1'b1;
                nxt.nest_depth = 16'd1;
                nxt.in_string = 1'b0;
                nxt.after_backslash = 1'b0;
                nxt.obj_byte_count = room ? 16'd1 : 16'd0;
                nxt.overflow_flag = !room;
                valid = room;
                in_object = 1'b1;
            end
        end else begin
            in_object = 1'b1;
            valid = room;
            if (room) begin
                nxt.obj_byte_count = s0.obj_byte_count + 16'd1;
            end else begin
                nxt.overflow_flag = 1'b1;
            end
            if (s0.in_string) begin
                if (s0.after_backslash) begin
                    nxt.after_backslash = 1'b0;
                end else if (in_byte == ChBackslash) begin
                    nxt.after_backslash = 1'b1;
                end else if (in_byte == ChQuote) begin
                    nxt.in_string = 1'b0;
                end
            end else if (in_byte == ChQuote) begin
                nxt.in_string = 1'b1;
            end else if (in_byte == ChLBrace || in_byte == ChLBracket) begin
                if (s0.nest_depth < DepthMax) begin
                    nxt.nest_depth = s0.nest_depth + 16'd1;
                end
            end else if (in_byte == ChRBrace || in_byte == ChRBracket) begin
                nxt.nest_depth = depth_dec;
                if (depth_dec == 16'd0) begin
                    close_obj = 1'b1;
                    nxt.capturing = 1'b0;
                    if (!nxt.overflow_flag && s0.object_count < max_objects) begin
                        nxt.object_count = s0.object_count + 8'd1;
                    end
                    if (nxt.object_count >= max_objects) begin
                        nxt.stopped = 1'b1;
                    end
                end
            end
        end

        res.byte_valid = valid;
        res.out_byte = valid ? in_byte : 8'd0;
        res.object_end = close_obj;
        res.object_overflowed = in_object && nxt.overflow_flag;
        res.objects_done = nxt.object_count;
        res.scan_stopped = nxt.stopped;
    end

endmodule

// ===== hdl/jkaof_checker.sv =====
// Port-level checker for the framer top level, with its bind.
module jkaof_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("stalled result beat changed");

    // empty output register never backpressures
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a closing byte is either stored or the object overflowed
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0] || m_tuser[1])
        else $error("object end neither stored nor overflowed");

    // unstored bytes read as zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("unstored byte not zero");

endmodule

bind json_keyed_array_object_framer_unit jkaof_checker u_jkaof_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
